>>> design/ppp_pkg.sv
// Shared constants, types and helper functions for the premultiplied pixel packer.
// Used by ppp_lane and premultiplied_pixel_packer_top; depends on nothing else.
package ppp_pkg;

	// Width of the packed output word and of the stored channel masks.
	localparam int WORD_WIDTH = 32;
	// Configuration data width: the widest register.
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	// Widths derived from the word width.
	localparam int CNT_W  = $clog2(WORD_WIDTH + 1);
	localparam int POS_W  = $clog2(WORD_WIDTH);
	localparam int KW     = WORD_WIDTH - 7;
	localparam int HI_W   = 8 + KW;
	localparam int PROD_W = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_RED_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_BITS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_EN   = 2'd3;

	// Reset values of the configuration registers, cut to the word.
	localparam logic [WORD_WIDTH-1:0] RED_BITS_RESET   = WORD_WIDTH'(32'h00FF_0000);
	localparam logic [WORD_WIDTH-1:0] GREEN_BITS_RESET = WORD_WIDTH'(32'h0000_FF00);
	localparam logic [WORD_WIDTH-1:0] BLUE_BITS_RESET  = WORD_WIDTH'(32'h0000_00FF);
	localparam logic                  ALPHA_EN_RESET   = 1'b1;

	// Field width (popcount) and position (lowest set bit) of one mask.
	typedef struct packed {
		logic [CNT_W-1:0] width;
		logic [POS_W-1:0] pos;
	} lane_info_t;

	// Width and position of a mask; a zero mask gives width zero.
	function automatic lane_info_t mask_info(input logic [WORD_WIDTH-1:0] m);
		lane_info_t info;
		info.width = '0;
		info.pos   = '0;
		for (int i = 0; i < WORD_WIDTH; i++) begin
			info.width = info.width + CNT_W'(m[i]);
		end
		for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
			if (m[i]) begin
				info.pos = POS_W'(i);
			end
		end
		return info;
	endfunction

	// Exact floor(x / 255) for any 16-bit x below 65280, where the quotient fits in eight bits.
	function automatic logic [7:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] acc;
		acc = (PROD_W+1)'(x) + (PROD_W+1)'(x[15:8]) + (PROD_W+1)'(1);
		return acc[15:8];
	endfunction

	// floor(2^w / 255): the sum of 2^(w - 8j) over every j >= 1 with 8j <= w.
	function automatic logic [KW-1:0] scale_k(input logic [CNT_W-1:0] w);
		logic [KW-1:0] k;
		k = '0;
		for (int j = 1; j <= WORD_WIDTH / 8; j++) begin
			if (int'(w) >= 8 * j) begin
				k = k | (KW'(1) << (int'(w) - 8 * j));
			end
		end
		return k;
	endfunction

endpackage

>>> design/ppp_lane.sv
// One channel of the packer: rescales an 8-bit value to its mask width and places it.
// Depends on ppp_pkg for widths, lane_info_t, div255 and scale_k.
module ppp_lane import ppp_pkg::*; (
	input  logic                  clk,
	input  logic [7:0]            pix,
	input  lane_info_t            info,
	output logic [WORD_WIDTH-1:0] field
);

	// With 2^w = 255*k + 2^m, (p*(2^w-1)+127)/255 = p*k + (p*(2^m-1)+127)/255.
	logic [HI_W-1:0]   hi_s4;
	logic [PROD_W-1:0] lo_s4;
	logic [7:0]        lo_quot;
	logic [HI_W-1:0]   scaled;

	// Stage four: the wide product and the small remainder numerator.
	always_ff @(posedge clk) begin
		hi_s4 <= HI_W'(pix) * HI_W'(scale_k(info.width));
		lo_s4 <= (PROD_W'(pix) << info.width[2:0]) - PROD_W'(pix) + PROD_W'(127);
	end

	// Finish the division, then shift the field to the mask's lowest set bit.
	always_comb begin
		lo_quot = div255(lo_s4);
		scaled  = hi_s4 + HI_W'(lo_quot);
		field   = WORD_WIDTH'(scaled) << info.pos;
	end

endmodule

>>> design/premultiplied_pixel_packer_top.sv
// Top level of the premultiplied pixel packer: premultiply, rescale and pack one pixel.
// Depends on ppp_pkg and instantiates ppp_lane for red, green, blue and alpha.
//
//  Channel  Signals                                   Handshake
//  -------  ----------------------------------------  ------------------------------
//  config   cfg_we, cfg_index, cfg_wdata              write at each edge with cfg_we
//  pixel    start, busy, red/green/blue/alpha_in      beat taken when start && !busy
//  result   done, packed_pixel                        one-cycle strobe, no back-pressure
//
// One pixel beat is taken every clock; busy is always low.
// A beat taken at one edge passes through each stage register in turn to packed_pixel,
// which it reaches with done high. Stages: input capture, premultiply product,
// divide by 255, rescale product, rescale finish and pack.
// Reset loads the documented mask and alpha enable values and clears all valid bits.
// The result side cannot stall, so the pipeline advances every cycle.
module premultiplied_pixel_packer_top import ppp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic [7:0]            red_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            blue_in,
	input  logic [7:0]            alpha_in,
	output logic                  done,
	output logic [WORD_WIDTH-1:0] packed_pixel
);

	// Configuration registers.
	logic [WORD_WIDTH-1:0] red_bits_q;
	logic [WORD_WIDTH-1:0] green_bits_q;
	logic [WORD_WIDTH-1:0] blue_bits_q;
	logic                  alpha_en_q;

	// Mask geometry, recomputed from the registers every cycle.
	lane_info_t            red_info_q;
	lane_info_t            green_info_q;
	lane_info_t            blue_info_q;
	lane_info_t            alpha_info_q;
	logic [WORD_WIDTH-1:0] alpha_mask;
	lane_info_t            alpha_info_d;

	// Pipeline.
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [7:0]            r_s1, g_s1, b_s1, a_s1;
	logic [PROD_W-1:0]     r_s2, g_s2, b_s2;
	logic [7:0]            a_s2;
	logic [7:0]            r_s3, g_s3, b_s3, a_s3;
	logic [WORD_WIDTH-1:0] red_field, green_field, blue_field, alpha_field;
	logic [WORD_WIDTH-1:0] packed_s5;

	assign busy = 1'b0;

	// Register writes from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_bits_q   <= RED_BITS_RESET;
			green_bits_q <= GREEN_BITS_RESET;
			blue_bits_q  <= BLUE_BITS_RESET;
			alpha_en_q   <= ALPHA_EN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RED_BITS: begin
					red_bits_q <= WORD_WIDTH'(cfg_wdata);
				end
				CFG_GREEN_BITS: begin
					green_bits_q <= WORD_WIDTH'(cfg_wdata);
				end
				CFG_BLUE_BITS: begin
					blue_bits_q <= WORD_WIDTH'(cfg_wdata);
				end
				CFG_ALPHA_EN: begin
					alpha_en_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Alpha takes the bits left free by the color masks; disabled alpha gets width zero.
	always_comb begin
		alpha_mask   = ~(red_bits_q | green_bits_q | blue_bits_q);
		alpha_info_d = mask_info(alpha_mask);
		if (!alpha_en_q) begin
			alpha_info_d.width = '0;
		end
	end

	// Geometry is registered and read only by the lanes in stages four and five, so it settles in time.
	always_ff @(posedge clk) begin
		red_info_q   <= mask_info(red_bits_q);
		green_info_q <= mask_info(green_bits_q);
		blue_info_q  <= mask_info(blue_bits_q);
		alpha_info_q <= alpha_info_d;
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage one captures the pixel; stage two forms c*a + 127.
	always_ff @(posedge clk) begin
		r_s1 <= red_in;
		g_s1 <= green_in;
		b_s1 <= blue_in;
		a_s1 <= alpha_in;
		r_s2 <= PROD_W'(r_s1) * PROD_W'(a_s1) + PROD_W'(127);
		g_s2 <= PROD_W'(g_s1) * PROD_W'(a_s1) + PROD_W'(127);
		b_s2 <= PROD_W'(b_s1) * PROD_W'(a_s1) + PROD_W'(127);
		a_s2 <= a_s1;
	end

	// Stage three divides by 255 to give the premultiplied colors.
	always_ff @(posedge clk) begin
		r_s3 <= div255(r_s2);
		g_s3 <= div255(g_s2);
		b_s3 <= div255(b_s2);
		a_s3 <= a_s2;
	end

	// Stages four and five: one rescaling lane per channel.
	ppp_lane u_red_lane (
		.clk   (clk),
		.pix   (r_s3),
		.info  (red_info_q),
		.field (red_field)
	);

	ppp_lane u_green_lane (
		.clk   (clk),
		.pix   (g_s3),
		.info  (green_info_q),
		.field (green_field)
	);

	ppp_lane u_blue_lane (
		.clk   (clk),
		.pix   (b_s3),
		.info  (blue_info_q),
		.field (blue_field)
	);

	ppp_lane u_alpha_lane (
		.clk   (clk),
		.pix   (a_s3),
		.info  (alpha_info_q),
		.field (alpha_field)
	);

	// Stage five merges the channel fields into the output word.
	always_ff @(posedge clk) begin
		packed_s5 <= red_field | green_field | blue_field | alpha_field;
	end

	assign done         = vld_s5;
	assign packed_pixel = packed_s5;

endmodule
